FILE: design/wildcard_byte_pattern_scan_top_defines.svh
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan assertion macros
// Clocked, reset-gated property wrappers used by the scan match core.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH

// Same-cycle implication on clk, off while rst_n is low.
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst_n is low.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/wbps_pkg.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan package
// Register map, field widths and the structs passed between modules.
// ---------------------------------------------------------------------------
package wbps_pkg;

  localparam int BYTE_W            = 8;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_ADDR_W        = 5;
  localparam int LEN_REG_W         = 5;
  localparam int OUT_OFFSET_W      = 32;
  localparam int PATTERN_REG_BYTES = 16;

  // Register index, taken from paddr[4:3] (8-byte spacing)
  localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

  localparam logic [LEN_REG_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [LEN_REG_W-1:0]  pattern_length;
  } wbps_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;
  } wbps_res_t;

endpackage

FILE: design/wildcard_byte_pattern_scan_top.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan
// Finds the first match of a wildcard byte pattern in each region of bytes.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tdata = data_byte, tlast = last_byte
//   out_     out  out_tvalid/out_tready tdata = match_offset, tuser = found
//   cfg_     in   APB write/read        pattern_low, pattern_high, pattern_length
//
// One byte per cycle sustained while the output is not stalled; a byte waits in the input register,
// the window compare sits between that register and the output register.
// A result, given on a match or on a region's last byte, is registered as its byte leaves the input register.
// Reset (synchronous, rst_n low) empties both registers and clears region state.
// A stalled output blocks the input register; new words are still taken while the input register is
// empty, or while the output register is free or being drained in the same cycle.
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_scan_top #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [7:0] data_byte
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tlast,
  // out_tdata: [31:0] match_offset
  output logic [31:0]                     out_tdata,
  // out_tuser: [0] found
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import wbps_pkg::*;

  wbps_cfg_t               cfg;
  wbps_res_t               res;

  logic                    in_valid_r;
  logic [BYTE_W-1:0]       in_byte_r;
  logic                    in_last_r;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [OUT_OFFSET_W-1:0] out_offset_r;
  logic                    out_free;
  logic                    advance;

  wbps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  wbps_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= advance && res.valid;
      end
    end
  end

  // hold payload until the next word moves in
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && res.valid) begin
      out_found_r  <= res.found;
      out_offset_r <= res.match_offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_offset_r;

endmodule

FILE: design/wbps_cfg.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan configuration registers
// APB-style write/read of pattern_low, pattern_high and pattern_length.
// ---------------------------------------------------------------------------
module wbps_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output wbps_pkg::wbps_cfg_t               cfg
);
  import wbps_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  logic [LEN_REG_W-1:0]  pattern_length_r;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= PATTERN_LENGTH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_pwdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_pwdata;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_pwdata[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LOW:    cfg_prdata = pattern_low_r;
      REG_PATTERN_HIGH:   cfg_prdata = pattern_high_r;
      REG_PATTERN_LENGTH: cfg_prdata = {{(CFG_DATA_W-LEN_REG_W){1'b0}}, pattern_length_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign cfg.pattern_low    = pattern_low_r;
  assign cfg.pattern_high   = pattern_high_r;
  assign cfg.pattern_length = pattern_length_r;

endmodule

FILE: design/wbps_match.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan match core
// Byte window, fill and position counters, and the parallel wildcard compare.
// ---------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_top_defines.svh"

module wbps_match #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [wbps_pkg::BYTE_W-1:0]     data_byte,
  input  logic                            last_byte,
  input  wbps_pkg::wbps_cfg_t             cfg,
  output wbps_pkg::wbps_res_t             res
);
  import wbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // window entry 0 is the newest byte
  logic [BYTE_W-1:0]      win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]      win_nxt [MAX_PATTERN];
  logic [LEN_W-1:0]       fill_r, fill_nxt, fill_sh;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, pos_sh, pos_diff;
  logic                   reported_r, reported_nxt;

  logic [LEN_W-1:0]       len;
  logic [BYTE_W-1:0]      pat     [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_ok;
  logic                   hit;
  logic [2*CFG_DATA_W-1:0] pat_all;

  assign pat_all = {cfg.pattern_high, cfg.pattern_low};

  // zero means one byte; clamp to the window depth
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(cfg.pattern_length);
    end
  end

  always_comb begin
    win_nxt[0] = data_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  assign fill_sh = (fill_r == LEN_W'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;
  assign pos_sh  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
  assign pos_diff = pos_sh - OFFSET_BITS'(len);

  // pattern byte i lines up with the byte len-1-i places back
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
    if (i < PATTERN_REG_BYTES) begin : g_reg
      assign pat[i] = pat_all[BYTE_W*i +: BYTE_W];
    end else begin : g_wild
      assign pat[i] = '0;
    end

    logic [IDX_W-1:0] age;
    assign age = IDX_W'(len - LEN_W'(i) - LEN_W'(1));
    assign lane_ok[i] = (LEN_W'(i) >= len) || (pat[i] == '0) || (pat[i] == win_nxt[age]);
  end

  assign hit = (fill_sh >= len) && (&lane_ok);

  always_comb begin
    res          = '0;
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    reported_nxt = reported_r;
    if (reported_r) begin
      if (last_byte) begin
        fill_nxt     = '0;
        pos_nxt      = '0;
        reported_nxt = 1'b0;
      end
    end else begin
      fill_nxt         = fill_sh;
      pos_nxt          = pos_sh;
      res.valid        = hit | last_byte;
      res.found        = hit;
      res.match_offset = hit ? OUT_OFFSET_W'(pos_diff) : '0;
      if (last_byte) begin
        fill_nxt     = '0;
        pos_nxt      = '0;
        reported_nxt = 1'b0;
      end else begin
        reported_nxt = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      pos_r      <= '0;
      reported_r <= 1'b0;
    end else if (step) begin
      fill_r     <= fill_nxt;
      pos_r      <= pos_nxt;
      reported_r <= reported_nxt;
    end
  end

  // window bytes beyond the fill count are never compared: no reset needed
  always_ff @(posedge clk) begin
    if (step && !reported_r) begin
      win_r <= win_nxt;
    end
  end

  `WBPS_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= LEN_W'(MAX_PATTERN), "fill above depth")
  `WBPS_ASSERT_NOW(a_quiet_after_match, step && reported_r, !res.valid, "result after match")
  `WBPS_ASSERT_NEXT(a_match_sets_flag, step && res.found && !last_byte, reported_r, "match flag lost")
  `WBPS_ASSERT_NEXT(a_last_clears, step && last_byte, (fill_r == '0) && (pos_r == '0) && !reported_r, "region not cleared")

endmodule

FILE: dv/tb_wildcard_byte_pattern_scan_top.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan testbench
// Streams byte regions into the scanner and checks every found/offset result
// against a cycle-free predictor of the window compare. The pattern registers
// are reprogrammed over the APB port while the block is idle. Directed words
// come first, then random regions that mostly embed the pattern. Both sides
// idle at random, and one long output stall lets the block back up.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scan_top;
  import wbps_pkg::*;

  localparam int WINDOW_DEPTH = 16;
  localparam int STALL_CYCLES = 300;

  typedef struct {
    logic        found;
    logic [31:0] offset;
  } scan_result_t;

  class match_scoreboard;
    logic [7:0]            window [WINDOW_DEPTH];
    int unsigned           fill;
    longint unsigned       position;
    bit                    reported;
    logic [63:0]           pat_lo;
    logic [63:0]           pat_hi;
    logic [LEN_REG_W-1:0]  pat_len;
    scan_result_t          pending_matches[$];
    int                    errors;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = PATTERN_LENGTH_RESET;
      errors  = 0;
      clear_region();
    endfunction

    function void clear_region();
      int i;
      for (i = 0; i < WINDOW_DEPTH; i++) window[i] = 8'h00;
      fill     = 0;
      position = 0;
      reported = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_LOW:    pat_lo  = value;
        REG_PATTERN_HIGH:   pat_hi  = value;
        REG_PATTERN_LENGTH: pat_len = value[LEN_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_at(int unsigned k);
      if (k < 8) return pat_lo[8*k +: 8];
      if (k < 16) return pat_hi[8*(k-8) +: 8];
      return 8'h00;
    endfunction

    // Zero length acts as one, anything past the window depth is clamped.
    function int unsigned active_len();
      int unsigned len;
      len = pat_len;
      if (len == 0) len = 1;
      if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
      return len;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned  len;
      int unsigned  i;
      bit           hit;
      logic [7:0]   p;
      scan_result_t r;
      if (reported) begin
        // drop the rest of a region once its match went out
        if (last) clear_region();
        return;
      end
      for (i = 0; i + 1 < WINDOW_DEPTH; i++) window[i] = window[i+1];
      window[WINDOW_DEPTH-1] = b;
      if (fill < WINDOW_DEPTH) fill++;
      if (position < 64'hFFFF_FFFF) position++;
      len = active_len();
      hit = (fill >= len);
      for (i = 0; i < len && hit; i++) begin
        p = pattern_at(i);
        if (p != 8'h00 && p != window[WINDOW_DEPTH - len + i]) hit = 1'b0;
      end
      if (hit) begin
        r.found  = 1'b1;
        r.offset = 32'(position - len);
        pending_matches.insert(pending_matches.size(), r);
        if (last) clear_region();
        else reported = 1'b1;
      end else if (last) begin
        r.found  = 1'b0;
        r.offset = 32'h0;
        pending_matches.insert(pending_matches.size(), r);
        clear_region();
      end
    endfunction

    function void check_match(logic found, logic [31:0] offset);
      scan_result_t e;
      if (pending_matches.size() == 0) begin
        $display("%0t: result without a pending word, found %0d offset %0d",
                 $time, found, offset);
        errors++;
        return;
      end
      e = pending_matches.pop_front();
      if (found !== e.found) begin
        $display("%0t: found mismatch, expected %0d, actual %0d", $time, e.found, found);
        errors++;
      end
      if (offset !== e.offset) begin
        $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                 $time, e.offset, offset);
        errors++;
      end
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic [7:0]            in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic                  in_tlast;
  logic [31:0]           out_tdata;   // [31:0] match_offset
  logic                  out_tuser;   // [0] found
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  match_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              items_sent;
  bit              stall_burst_req;

  wildcard_byte_pattern_scan_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Check results before noting inputs taken on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_match(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    end
  end

  // Output side: random backpressure, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_burst_req) begin
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_burst_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= b;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Wait out pending results, then the pipeline depth for words with no result.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  function automatic logic [63:0] random_pattern_word();
    logic [63:0] w;
    int          k;
    for (k = 0; k < 8; k++) begin
      if ($urandom_range(3) == 0) w[8*k +: 8] = 8'h00;
      else w[8*k +: 8] = 8'($urandom_range(1, 255));
    end
    return w;
  endfunction

  task automatic program_phase(input int k);
    logic [63:0]          lo;
    logic [63:0]          hi;
    logic [LEN_REG_W-1:0] len;
    int                   r;
    lo = random_pattern_word();
    hi = random_pattern_word();
    case (k)
      4: begin
        lo = '0;
        hi = '0;
      end
      5: begin
        lo = '1;
        hi = '1;
      end
      default: ;
    endcase
    case (k)
      0: len = 5'd16;
      1: len = 5'd1;
      2: len = 5'd31;
      3: len = 5'd0;
      default: begin
        r = $urandom_range(19);
        if (r == 0) len = 5'($urandom_range(17, 31));
        else if (r == 1) len = 5'd0;
        else len = 5'($urandom_range(1, 16));
      end
    endcase
    cfg_write(REG_PATTERN_LENGTH, 64'(len));
    cfg_write(REG_PATTERN_HIGH, hi);
    cfg_write(REG_PATTERN_LOW, lo);
  endtask

  // Region with the pattern planted somewhere, now and then spoiled by one bit.
  task automatic send_planted_region();
    int unsigned plen;
    int unsigned rlen;
    int unsigned start;
    int unsigned j;
    logic [7:0]  b;
    logic [7:0]  p;
    bit          broken;
    plen = sb.active_len();
    if ($urandom_range(19) == 0) rlen = $urandom_range(plen, plen + 200);
    else rlen = $urandom_range(plen, plen + 20);
    if ($urandom_range(3) == 0) start = rlen - plen;
    else start = $urandom_range(0, rlen - plen);
    broken = ($urandom_range(6) == 0);
    for (j = 0; j < rlen; j++) begin
      b = 8'($urandom_range(255));
      if (j >= start && j < start + plen) begin
        p = sb.pattern_at(j - start);
        if (p != 8'h00) b = p;
        if (broken && j == start + plen - 1) b = b ^ (8'h01 << $urandom_range(7));
      end
      send_byte(b, j == rlen - 1);
    end
  endtask

  task automatic run_regions(input int target);
    int kind;
    int n;
    int j;
    items_sent = 0;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_planted_region();
      end else if (kind < 85) begin
        n = $urandom_range(1, 12);
        for (j = 0; j < n; j++) send_byte(8'($urandom_range(255)), j == n - 1);
      end else begin
        // loose bytes that run on into the next region
        n = $urandom_range(1, 8);
        for (j = 0; j < n; j++) send_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  initial begin
    int mode;
    int ph;
    int j;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_tdata        = 8'h00;
    in_tvalid       = 1'b0;
    in_tlast        = 1'b0;
    out_tready      = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    send_idle_pct   = 14;
    recv_idle_pct   = 49;
    stall_burst_req = 1'b0;
    sb              = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern: one wildcard byte, so the first byte of a region matches.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();

    // Zero length acts as one; match on the final byte, then a miss.
    cfg_write(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
    cfg_write(REG_PATTERN_HIGH, '1);
    cfg_write(REG_PATTERN_LENGTH, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    drain();

    // Oversized length clamps to the full window: short region, then a full match.
    cfg_write(REG_PATTERN_LOW, '1);
    cfg_write(REG_PATTERN_LENGTH, 64'd17);
    for (j = 0; j < 3; j++) send_byte(8'hFF, j == 2);
    for (j = 0; j < WINDOW_DEPTH; j++) send_byte(8'hFF, j == WINDOW_DEPTH - 1);
    drain();

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (ph = 0; ph < 4; ph++) begin
        program_phase(mode * 4 + ph);
        if (mode == 0 && ph == 1) stall_burst_req = 1'b1;
        run_regions(72);
        drain();
      end
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
